// ===== src/d2q_pkg.sv =====
// Package for the 2x2 block quantizer: constants, store entry type and code functions.
package d2q_pkg;

    // Store geometry
    localparam int MAX_BLOCK_COLUMNS = 1024;
    localparam int COL_W  = (MAX_BLOCK_COLUMNS > 1) ? $clog2(MAX_BLOCK_COLUMNS) : 1;
    localparam int COLS_W = 11;                   // block_columns register
    localparam int ROWS_W = 13;                   // block_rows register
    localparam int EFFC_W = (COL_W + 1 > COLS_W + 1) ? COL_W + 1 : COLS_W + 1;
    localparam int ROW_W  = ROWS_W;

    // Configuration port
    localparam int CFG_W     = 13;
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_BLOCK_COLUMNS = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BLOCK_ROWS    = 1'd1;
    localparam logic [COLS_W-1:0] COLS_RESET = 11'd320;
    localparam logic [ROWS_W-1:0] ROWS_RESET = 13'd240;

    // Field widths
    localparam int PIX_W  = 12;
    localparam int SUM_W  = 15;                   // sums of up to four pixels, signed
    localparam int ENT_W  = 13;                   // store entry fields
    localparam int M_W    = 23;                   // 511*S + 8190
    localparam int RCP_W  = 24;
    localparam int PROD_W = M_W + RCP_W;

    // a = floor((511*S + 8190) / 16380), done as an exact reciprocal multiply
    localparam int A_SHIFT = 37;
    localparam logic [RCP_W-1:0] A_RECIP = 24'd8390657;
    localparam logic [M_W-1:0]   A_ROUND = 23'd8190;

    // Difference code scaling: q = floor((10*|x| + 1638) / 3276)
    localparam int DIFF_W    = 19;
    localparam int DIFF_STEP = 3276;
    localparam int DIFF_MAX  = 15;

    // One top_row_store entry
    typedef struct packed {
        logic        [ENT_W-1:0] ysum;
        logic signed [ENT_W-1:0] ydiff;
        logic signed [ENT_W-1:0] pbsum;
        logic signed [ENT_W-1:0] prsum;
    } t_top_entry;

    localparam int ENTRY_W = $bits(t_top_entry);

    // Signed difference sum to a 5-bit code, clamped to +-15, half away from zero
    function automatic logic [4:0] diff_code(input logic signed [SUM_W-1:0] x);
        logic [SUM_W-1:0]  mag;
        logic [DIFF_W-1:0] scaled;
        logic [4:0]        q;
        mag    = x[SUM_W-1] ? SUM_W'(-x) : SUM_W'(x);
        scaled = DIFF_W'(mag) * DIFF_W'(10) + DIFF_W'(1638);
        q      = 5'd0;
        for (int k = 1; k <= DIFF_MAX; k++) begin
            if (scaled >= DIFF_W'(DIFF_STEP * k)) q = 5'(k);
        end
        return x[SUM_W-1] ? 5'(5'd0 - q) : q;
    endfunction

    // Sum of four chroma samples divided by 4, half away from zero
    function automatic logic [PIX_W-1:0] chroma_avg(input logic signed [SUM_W-1:0] s);
        logic [SUM_W-1:0] mag;
        logic [SUM_W-1:0] q;
        logic [SUM_W-1:0] res;
        mag = s[SUM_W-1] ? SUM_W'(-s) : SUM_W'(s);
        q   = (mag + SUM_W'(2)) >> 2;
        res = s[SUM_W-1] ? SUM_W'(SUM_W'(0) - q) : q;
        return res[PIX_W-1:0];
    endfunction

endpackage

// ===== src/d2q_ram.sv =====
// Generic simple dual-port RAM with registered read.
module d2q_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic                                   i_re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read port, data held until the next read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/dct2x2_block_quantizer.sv =====
// Top level of the 2x2 block transform quantizer.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+------------------------------------------
//  pixel   | in        | i_valid / o_ready  | i_luma, i_blue_diff, i_red_diff
//  block   | out       | o_valid / i_ready  | o_a_code, o_b/c/d_code, o_blue/red_avg,
//          |           |                    | o_frame_end
//  config  | in        | i_cfg_we           | i_cfg_idx, i_cfg_wdata
//
// One pixel per cycle while o_ready is high. A result leaves after the block's
// bottom-right pixel: one stage of sums, one of reciprocal multiply and coding.
// The top-row store is read when the bottom-left pixel is taken, so its data sits
// in the RAM read register when the bottom-right pixel arrives.
// Reset clears counters, valids and the config registers; no store clearing
// pass is needed; each entry is written on a top row before a bottom row reads it.
// o_ready drops only while both pipeline stages hold results and i_ready is low.
module dct2x2_block_quantizer
    import d2q_pkg::*;
(
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // configuration
    input  logic                        i_cfg_we,
    input  logic [CFG_IDX_W-1:0]        i_cfg_idx,
    input  logic [CFG_W-1:0]            i_cfg_wdata,
    // pixel in
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [PIX_W-1:0]            i_luma,
    input  logic signed [PIX_W-1:0]     i_blue_diff,
    input  logic signed [PIX_W-1:0]     i_red_diff,
    // block out
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [8:0]                  o_a_code,
    output logic signed [4:0]           o_b_code,
    output logic signed [4:0]           o_c_code,
    output logic signed [4:0]           o_d_code,
    output logic signed [PIX_W-1:0]     o_blue_avg,
    output logic signed [PIX_W-1:0]     o_red_avg,
    output logic                        o_frame_end
);

    // configuration and position state
    logic [COLS_W-1:0] r_cols;
    logic [ROWS_W-1:0] r_rows;
    logic [COL_W-1:0]  r_col_cnt, n_col_cnt;
    logic [ROW_W-1:0]  r_row_cnt, n_row_cnt;
    logic              r_col_ph, n_col_ph;
    logic              r_row_ph, n_row_ph;

    // left pixel of the current block row
    logic [PIX_W-1:0]        r_left_luma;
    logic signed [PIX_W-1:0] r_left_pb;
    logic signed [PIX_W-1:0] r_left_pr;

    // pipeline stages
    logic                    r_s1_v, n_s1_v;
    logic [M_W-1:0]          r_s1_m;
    logic signed [SUM_W-1:0] r_s1_b, r_s1_c, r_s1_d, r_s1_pb, r_s1_pr;
    logic                    r_s1_fe;
    logic                    r_out_v, n_out_v;
    logic [8:0]              r_a;
    logic [4:0]              r_b, r_c, r_d;
    logic [PIX_W-1:0]        r_pb, r_pr;
    logic                    r_fe;

    // combinational
    logic [EFFC_W-1:0]       w_cols_eff;
    logic [ROWS_W-1:0]       w_rows_eff;
    logic                    w_last_col, w_last_row;
    logic                    w_accept, w_emit, w_out_take, w_s1_take;
    logic                    w_ram_we, w_ram_re;
    t_top_entry              w_wentry, w_rentry;
    logic signed [SUM_W-1:0] w_y, w_l, w_pb, w_lpb, w_pr, w_lpr;
    logic signed [SUM_W-1:0] w_tys, w_tyd, w_tpb, w_tpr;
    logic signed [SUM_W-1:0] w_s, w_bsum, w_csum, w_dsum, w_pbs, w_prs;
    logic [M_W-1:0]          w_m;
    logic [PROD_W-1:0]       w_prod;

    // effective register values: zero acts as one, columns capped at store depth
    always_comb begin
        if (r_cols == '0) begin
            w_cols_eff = EFFC_W'(1);
        end else if (EFFC_W'(r_cols) > EFFC_W'(MAX_BLOCK_COLUMNS)) begin
            w_cols_eff = EFFC_W'(MAX_BLOCK_COLUMNS);
        end else begin
            w_cols_eff = EFFC_W'(r_cols);
        end
        w_rows_eff = (r_rows == '0) ? ROWS_W'(1) : r_rows;
    end

    assign w_last_col = (EFFC_W'(r_col_cnt) + EFFC_W'(1)) >= w_cols_eff;
    assign w_last_row = ((ROW_W + 1)'(r_row_cnt) + (ROW_W + 1)'(1))
                        >= (ROW_W + 1)'(w_rows_eff);

    // handshake: the output register and stage 1 each take a new item when free
    assign w_out_take = !r_out_v || i_ready;
    assign w_s1_take  = !r_s1_v || w_out_take;
    assign o_ready    = w_s1_take;
    assign w_accept   = i_valid && o_ready;
    assign w_emit     = r_col_ph && r_row_ph;

    // store access: write on top-row right pixel, read on bottom-row left pixel
    assign w_ram_we = w_accept && r_col_ph && !r_row_ph;
    assign w_ram_re = w_accept && !r_col_ph && r_row_ph;

    // widen operands
    assign w_y   = SUM_W'(signed'({3'b000, i_luma}));
    assign w_l   = SUM_W'(signed'({3'b000, r_left_luma}));
    assign w_pb  = SUM_W'(i_blue_diff);
    assign w_lpb = SUM_W'(r_left_pb);
    assign w_pr  = SUM_W'(i_red_diff);
    assign w_lpr = SUM_W'(r_left_pr);
    assign w_tys = SUM_W'(signed'({2'b00, w_rentry.ysum}));
    assign w_tyd = SUM_W'(w_rentry.ydiff);
    assign w_tpb = SUM_W'(w_rentry.pbsum);
    assign w_tpr = SUM_W'(w_rentry.prsum);

    // top-row entry
    always_comb begin
        w_wentry.ysum  = ENT_W'(w_l + w_y);
        w_wentry.ydiff = ENT_W'(w_y - w_l);
        w_wentry.pbsum = ENT_W'(w_lpb + w_pb);
        w_wentry.prsum = ENT_W'(w_lpr + w_pr);
    end

    // block sums at the bottom-right pixel
    always_comb begin
        w_s    = w_tys + w_l + w_y;
        w_bsum = (w_l + w_y) - w_tys;
        w_csum = w_tyd + w_y - w_l;
        w_dsum = w_y - w_l - w_tyd;
        w_pbs  = w_tpb + w_lpb + w_pb;
        w_prs  = w_tpr + w_lpr + w_pr;
        // 511*S + 8190, S is never negative
        w_m    = (M_W'(w_s) << 9) - M_W'(w_s) + A_ROUND;
    end

    d2q_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_BLOCK_COLUMNS)
    ) u_top_store (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (r_col_cnt),
        .i_wdata (w_wentry),
        .i_re    (w_ram_re),
        .i_raddr (r_col_cnt),
        .o_rdata (w_rentry)
    );

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cols <= COLS_RESET;
            r_rows <= ROWS_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_BLOCK_COLUMNS: r_cols <= i_cfg_wdata[COLS_W-1:0];
                REG_BLOCK_ROWS:    r_rows <= i_cfg_wdata[ROWS_W-1:0];
                default: ;
            endcase
        end
    end

    // position next state
    always_comb begin
        n_col_cnt = r_col_cnt;
        n_row_cnt = r_row_cnt;
        n_col_ph  = r_col_ph;
        n_row_ph  = r_row_ph;
        if (w_accept) begin
            if (!r_col_ph) begin
                n_col_ph = 1'b1;
            end else begin
                n_col_ph = 1'b0;
                if (!w_last_col) begin
                    n_col_cnt = r_col_cnt + COL_W'(1);
                end else begin
                    n_col_cnt = '0;
                    n_row_ph  = !r_row_ph;
                    if (r_row_ph) begin
                        n_row_cnt = w_last_row ? '0 : r_row_cnt + ROW_W'(1);
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col_cnt <= '0;
            r_row_cnt <= '0;
            r_col_ph  <= 1'b0;
            r_row_ph  <= 1'b0;
        end else begin
            r_col_cnt <= n_col_cnt;
            r_row_cnt <= n_row_cnt;
            r_col_ph  <= n_col_ph;
            r_row_ph  <= n_row_ph;
        end
    end

    // latch left pixel
    always_ff @(posedge i_clk) begin
        if (w_accept && !r_col_ph) begin
            r_left_luma <= i_luma;
            r_left_pb   <= i_blue_diff;
            r_left_pr   <= i_red_diff;
        end
    end

    // stage valids
    assign n_s1_v  = (w_accept && w_emit) || (r_s1_v && !w_out_take);
    assign n_out_v = (r_s1_v && w_out_take) || (r_out_v && !i_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v  <= 1'b0;
            r_out_v <= 1'b0;
        end else begin
            r_s1_v  <= n_s1_v;
            r_out_v <= n_out_v;
        end
    end

    // stage 1: block sums
    always_ff @(posedge i_clk) begin
        if (w_accept && w_emit) begin
            r_s1_m  <= w_m;
            r_s1_b  <= w_bsum;
            r_s1_c  <= w_csum;
            r_s1_d  <= w_dsum;
            r_s1_pb <= w_pbs;
            r_s1_pr <= w_prs;
            r_s1_fe <= w_last_col && w_last_row;
        end
    end

    // stage 2: reciprocal multiply for a, coding of the rest
    assign w_prod = PROD_W'(r_s1_m) * PROD_W'(A_RECIP);

    always_ff @(posedge i_clk) begin
        if (r_s1_v && w_out_take) begin
            r_a  <= w_prod[A_SHIFT +: 9];
            r_b  <= diff_code(r_s1_b);
            r_c  <= diff_code(r_s1_c);
            r_d  <= diff_code(r_s1_d);
            r_pb <= chroma_avg(r_s1_pb);
            r_pr <= chroma_avg(r_s1_pr);
            r_fe <= r_s1_fe;
        end
    end

    assign o_valid     = r_out_v;
    assign o_a_code    = r_a;
    assign o_b_code    = r_b;
    assign o_c_code    = r_c;
    assign o_d_code    = r_d;
    assign o_blue_avg  = r_pb;
    assign o_red_avg   = r_pr;
    assign o_frame_end = r_fe;

endmodule

// ===== src/d2q_checker.sv =====
// Port-level checks for the 2x2 block quantizer, bound to the top level.
module d2q_checker
    import d2q_pkg::*;
(
    input logic                    i_clk,
    input logic                    i_rst_n,
    input logic                    o_ready,
    input logic                    o_valid,
    input logic                    i_ready,
    input logic [8:0]              o_a_code,
    input logic signed [4:0]       o_b_code,
    input logic signed [4:0]       o_c_code,
    input logic signed [4:0]       o_d_code,
    input logic signed [PIX_W-1:0] o_blue_avg,
    input logic                    o_frame_end
);

    // a stalled result stays put
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_a_code) && $stable(o_blue_avg)
                                && $stable(o_frame_end))
        else $error("result changed while stalled");

    // reset leaves no result pending
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

    // difference codes never reach -16
    a_code_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_b_code != 5'sb10000 && o_c_code != 5'sb10000
                    && o_d_code != 5'sb10000)
        else $error("difference code out of range");

    // input side never stalls while the output side is free
    a_no_idle_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> o_ready)
        else $error("input stalled with empty output");

endmodule

bind dct2x2_block_quantizer d2q_checker u_d2q_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_ready     (o_ready),
    .o_valid     (o_valid),
    .i_ready     (i_ready),
    .o_a_code    (o_a_code),
    .o_b_code    (o_b_code),
    .o_c_code    (o_c_code),
    .o_d_code    (o_d_code),
    .o_blue_avg  (o_blue_avg),
    .o_frame_end (o_frame_end)
);
